[rtl/rif_pkg.sv]
// rif_pkg: shared types, character codes and helpers of the radix integer formatter
// no dependencies; used by rif_front, rif_back and radix_integer_formatter
package rif_pkg;

   // radix limits and fallback
   localparam int unsigned RADIX_W        = 6;
   localparam logic [7:0]  RADIX_MIN      = 8'd2;
   localparam logic [7:0]  RADIX_MAX      = 8'd36;
   localparam logic [5:0]  RADIX_FALLBACK = 6'd10;

   // ascii codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER = 8'h41;
   localparam logic [7:0] CHAR_LOWER = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;

   // quotient bits resolved per cycle in the remainder unit
   localparam int unsigned BITS_PER_CYCLE = 8;

   // job flags handed from the front to the back through the queue
   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic               upper;
      logic               negative;
   } job_flags_type;

   // back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_EMIT
   } back_state_type;

   // digit value to ascii, letters for ten and above
   function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] digit,
                                              input logic upper);
      logic [7:0] d8;
      d8 = {2'b00, digit};
      if (digit < 6'd10) begin
         return CHAR_ZERO + d8;
      end
      return (upper ? CHAR_UPPER : CHAR_LOWER) + (d8 - 8'd10);
   endfunction

endpackage

[rtl/rif_front.sv]
// rif_front: accepts input words and classifies them into sign, magnitude and radix
// depends on rif_pkg
module rif_front #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                   req_valid,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [7:0]             req_base,
   input  logic                   req_upper,
   output logic                   req_ready,
   output logic                   job_valid,
   input  logic                   job_ready,
   output logic [VALUE_WIDTH-1:0] job_mag,
   output rif_pkg::job_flags_type job_flags
);

   logic negative;
   logic base_ok;

   // sign and unsigned magnitude, the most negative value maps to 2^(w-1)
   assign negative = req_value[VALUE_WIDTH-1];
   assign job_mag  = negative ? (~req_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : req_value;

   // bases outside the legal range fall back to decimal
   assign base_ok = (req_base >= rif_pkg::RADIX_MIN) && (req_base <= rif_pkg::RADIX_MAX);

   always_comb begin
      job_flags.radix    = base_ok ? req_base[rif_pkg::RADIX_W-1:0] : rif_pkg::RADIX_FALLBACK;
      job_flags.upper    = req_upper;
      job_flags.negative = negative;
   end

   // handshake straight onto the queue
   assign job_valid = req_valid;
   assign req_ready = job_ready;

endmodule

[rtl/rif_queue.sv]
// rif_queue: two-entry queue that decouples the front from the back
// no dependencies
module rif_queue #(
   parameter int unsigned WIDTH = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic [WIDTH-1:0] entry_in [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = in_data;
         wr_ptr_in           = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[rtl/rif_back.sv]
// rif_back: repeated division by the radix, digit stack and character output register
// depends on rif_pkg
module rif_back #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  logic [VALUE_WIDTH-1:0] job_mag,
   input  rif_pkg::job_flags_type job_flags,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int unsigned BPC      = rif_pkg::BITS_PER_CYCLE;
   localparam int unsigned CHUNKS   = (VALUE_WIDTH + BPC - 1) / BPC;
   localparam int unsigned PW       = CHUNKS * BPC;
   localparam int unsigned CW       = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int unsigned DW       = $clog2(VALUE_WIDTH + 1);
   localparam int unsigned RW       = rif_pkg::RADIX_W;

   rif_pkg::back_state_type state_ff, state_in;
   logic [PW-1:0]     div_ff, div_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     chunk_ff, chunk_in;
   logic [RW-1:0]     radix_ff, radix_in;
   logic              upper_ff, upper_in;
   logic              sign_ff, sign_in;
   logic [DW-1:0]     depth_ff, depth_in;
   logic [RW-1:0]     stack_ff [VALUE_WIDTH];
   logic [RW-1:0]     stack_in [VALUE_WIDTH];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              out_free;
   logic [RW:0]       step_rem;
   logic [PW-1:0]     step_div;

   assign job_ready  = (state_ff == rif_pkg::BK_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // one chunk of restoring division by the radix, quotient bits shift in at the bottom
   always_comb begin
      step_rem = {1'b0, rem_ff};
      step_div = div_ff;
      for (int i = 0; i < BPC; i++) begin
         step_rem = {step_rem[RW-1:0], step_div[PW-1]};
         step_div = {step_div[PW-2:0], 1'b0};
         if (step_rem >= {1'b0, radix_ff}) begin
            step_rem    = step_rem - {1'b0, radix_ff};
            step_div[0] = 1'b1;
         end
      end
   end

   // sequencer: load job, divide digit by digit onto the stack, pop characters out
   always_comb begin
      state_in     = state_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      radix_in     = radix_ff;
      upper_in     = upper_ff;
      sign_in      = sign_ff;
      depth_in     = depth_ff;
      stack_in     = stack_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         rif_pkg::BK_IDLE: begin
            if (job_valid) begin
               div_in   = PW'(job_mag);
               rem_in   = '0;
               chunk_in = '0;
               radix_in = job_flags.radix;
               upper_in = job_flags.upper;
               sign_in  = job_flags.negative;
               depth_in = '0;
               state_in = rif_pkg::BK_DIVIDE;
            end
         end
         rif_pkg::BK_DIVIDE: begin
            div_in   = step_div;
            rem_in   = step_rem[RW-1:0];
            chunk_in = chunk_ff + {{(CW-1){1'b0}}, 1'b1};
            if (chunk_ff == CW'(CHUNKS - 1)) begin
               // digit done: push it, restart on the quotient or finish
               stack_in[0] = step_rem[RW-1:0];
               for (int i = 1; i < VALUE_WIDTH; i++) begin
                  stack_in[i] = stack_ff[i-1];
               end
               depth_in = depth_ff + {{(DW-1){1'b0}}, 1'b1};
               rem_in   = '0;
               chunk_in = '0;
               if (step_div == '0) begin
                  state_in = rif_pkg::BK_EMIT;
               end
            end
         end
         rif_pkg::BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sign_ff) begin
                  rsp_char_in = rif_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in = rif_pkg::digit_char(stack_ff[0], upper_ff);
                  rsp_last_in = (depth_ff == DW'(1));
                  for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
                     stack_in[i] = stack_ff[i+1];
                  end
                  depth_in = depth_ff - {{(DW-1){1'b0}}, 1'b1};
                  if (depth_ff == DW'(1)) begin
                     state_in = rif_pkg::BK_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = rif_pkg::BK_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rif_pkg::BK_IDLE;
         chunk_ff     <= '0;
         sign_ff      <= 1'b0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chunk_ff     <= chunk_in;
         sign_ff      <= sign_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      upper_ff    <= upper_in;
      stack_ff    <= stack_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // partial remainder always stays below the radix
   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rif_pkg::BK_DIVIDE) |-> (rem_ff < radix_ff))
      else $error("partial remainder reached the radix");

   // radix in use is always a legal one
   a_radix_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rif_pkg::BK_IDLE) |-> (radix_ff >= 6'd2 && radix_ff <= 6'd36))
      else $error("illegal radix in the divider");

   // emission never starts with an empty digit stack
   a_emit_has_digits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rif_pkg::BK_EMIT) |-> (depth_ff != '0 && depth_ff <= DW'(VALUE_WIDTH)))
      else $error("digit stack empty or overfull while emitting");

   // a marked last character always returns the sequencer to idle
   a_last_ends_job: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rif_pkg::BK_EMIT && rsp_valid_in && rsp_last_in && out_free)
      |=> (state_ff == rif_pkg::BK_IDLE))
      else $error("last character sent without ending the job");

endmodule

[rtl/radix_integer_formatter.sv]
// radix_integer_formatter: top level, signed integer to ascii text in radix 2 to 36
// depends on rif_pkg, rif_front, rif_queue, rif_back
//
//  channel | dir | tdata (low bit up)               | tuser      | tlast
//  req_    | in  | value, base, zero pad to bytes   | upper_case | -
//  rsp_    | out | character                        | -          | last
//
// each digit is found chunk by chunk in the shared remainder unit, which resolves 8
// quotient bits per cycle; characters leave at one per cycle while rsp_tready is high.
// reset clears the sequencer, queue and output valid; there is no clearing pass.
// a two-entry queue lets new words be taken while the back end is converting,
// and the output register holds a character for as long as rsp_tready is low.
module radix_integer_formatter #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [((VALUE_WIDTH + 15) / 8) * 8 - 1:0] req_tdata,   // value, base, zero pad
   input  logic                req_tuser,   // upper_case
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // character
   output logic                rsp_tlast
);

   localparam int unsigned FW    = $bits(rif_pkg::job_flags_type);
   localparam int unsigned QW    = VALUE_WIDTH + FW;

   logic                   front_valid, front_ready;
   logic [VALUE_WIDTH-1:0] front_mag;
   rif_pkg::job_flags_type front_flags;
   logic                   back_valid, back_ready;
   logic [QW-1:0]          back_data;
   rif_pkg::job_flags_type back_flags;

   // front end classification
   rif_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .req_valid (req_tvalid),
      .req_value (req_tdata[VALUE_WIDTH-1:0]),
      .req_base  (req_tdata[VALUE_WIDTH+7:VALUE_WIDTH]),
      .req_upper (req_tuser),
      .req_ready (req_tready),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job_mag   (front_mag),
      .job_flags (front_flags)
   );

   // job queue
   rif_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   ({front_mag, front_flags}),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_data  (back_data)
   );

   assign back_flags = back_data[FW-1:0];

   // back end conversion and output
   rif_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (back_valid),
      .job_ready  (back_ready),
      .job_mag    (back_data[QW-1:FW]),
      .job_flags  (back_flags),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
